### rtl/aabb_obstacle_table_check_unit_macros.svh
// Assertion macros used by the checker of the obstacle table.
`ifndef AABB_OBSTACLE_TABLE_CHECK_UNIT_MACROS_SVH
`define AABB_OBSTACLE_TABLE_CHECK_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AOTC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aotc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define AOTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aotc assertion failed");

`endif

### rtl/aotc_pkg.sv
package aotc_pkg;

    localparam int COORD_W = 32;
    localparam int BOX_W   = 6 * COORD_W;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_POINT = 2'd1;
    localparam logic [1:0] OP_BOX   = 2'd2;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
    } in_item_t;

    typedef struct packed {
        logic clear;
        logic status;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] lo_x;
        logic signed [COORD_W-1:0] lo_y;
        logic signed [COORD_W-1:0] lo_z;
        logic signed [COORD_W-1:0] hi_x;
        logic signed [COORD_W-1:0] hi_y;
        logic signed [COORD_W-1:0] hi_z;
    } box_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic finish;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_needed;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

### rtl/aotc_stream_if.sv
interface aotc_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/aabb_obstacle_table_check_unit.sv
// Channel  Role    Payload     Content
// in_ch    sink    in_item_t   opcode, a_x/a_y/a_z, b_x/b_y/b_z
// out_ch   source  out_item_t  clear, status
//
// An add, an unused opcode or a query on an empty table goes from transfer
// straight to the result state; a query on a table of N > 0 boxes first scans
// the box RAM, one stored box read per cycle, then drains the last compare.
// rst_n clears the box count and the control state; the box RAM is not cleared.
// A new item is taken while a finished result waits on out_ch; its own result
// is held back until the waiting one has been transferred.
module aabb_obstacle_table_check_unit import aotc_pkg::*; #(
    parameter int MAX_BOXES = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    aotc_stream_if.sink   in_ch,
    aotc_stream_if.source out_ch
);

    cmd_t cmd;
    sts_t sts;

    aotc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    aotc_datapath #(
        .MAX_BOXES (MAX_BOXES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_payload  (in_ch.payload),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_payload (out_ch.payload)
    );

endmodule

### rtl/aotc_ram.sv
module aotc_ram #(
    parameter int WIDTH = 192,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/aotc_ctrl.sv
module aotc_ctrl import aotc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.finish    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.scan_needed ? S_SCAN : S_RESULT;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            // The last entry read is compared in this cycle.
            S_DRAIN:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/aotc_datapath.sv
module aotc_datapath import aotc_pkg::*; #(
    parameter int MAX_BOXES = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_payload,
    input  cmd_t      cmd,
    output sts_t      sts,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_payload
);

    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] rd_idx_next;
    logic          cmp_en_reg;
    logic          hit_reg;
    logic          hit_next;
    logic [1:0]    op_reg;
    logic          full_reg;
    box_t          query_reg;
    logic          out_valid_reg;
    out_item_t     out_reg;
    out_item_t     out_next;

    logic          full;
    logic          add_ok;
    box_t          new_box;
    logic [BOX_W-1:0] rd_data;
    box_t          entry;
    logic          overlap;

    assign full   = (count_reg == CW'(MAX_BOXES));
    assign add_ok = cmd.load && (in_payload.opcode == OP_ADD) && !full;

    assign new_box.lo_x = in_payload.a_x;
    assign new_box.lo_y = in_payload.a_y;
    assign new_box.lo_z = in_payload.a_z;
    assign new_box.hi_x = in_payload.b_x;
    assign new_box.hi_y = in_payload.b_y;
    assign new_box.hi_z = in_payload.b_z;

    aotc_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_BOXES)
    ) u_box_ram (
        .clk   (clk),
        .we    (add_ok),
        .waddr (count_reg[AW-1:0]),
        .wdata (new_box),
        .re    (cmd.scan_step),
        .raddr (rd_idx_reg),
        .rdata (rd_data)
    );

    assign entry = rd_data;

    // A point query is held as a degenerate box, so one overlap test serves both.
    assign overlap = (query_reg.lo_x <= entry.hi_x) && (query_reg.hi_x >= entry.lo_x) &&
                     (query_reg.lo_y <= entry.hi_y) && (query_reg.hi_y >= entry.lo_y) &&
                     (query_reg.lo_z <= entry.hi_z) && (query_reg.hi_z >= entry.lo_z);

    assign count_next  = add_ok ? count_reg + CW'(1) : count_reg;
    assign rd_idx_next = cmd.load ? '0 : (cmd.scan_step ? rd_idx_reg + AW'(1) : rd_idx_reg);
    assign hit_next    = cmd.load ? 1'b0 : (hit_reg || (cmp_en_reg && overlap));

    always_comb
    begin
        out_next.clear  = 1'b0;
        out_next.status = 1'b0;
        case (op_reg)
            OP_ADD:
            begin
                out_next.status = full_reg;
            end
            OP_POINT:
            begin
                out_next.clear = !query_reg.lo_y[COORD_W-1] && !hit_reg;
            end
            OP_BOX:
            begin
                out_next.clear = !hit_reg;
            end
            default:
            begin
                out_next.clear = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            cmp_en_reg <= cmd.scan_step;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        if (cmd.load)
        begin
            op_reg         <= in_payload.opcode;
            full_reg       <= full;
            query_reg.lo_x <= in_payload.a_x;
            query_reg.lo_y <= in_payload.a_y;
            query_reg.lo_z <= in_payload.a_z;
            query_reg.hi_x <= (in_payload.opcode == OP_POINT) ? in_payload.a_x : in_payload.b_x;
            query_reg.hi_y <= (in_payload.opcode == OP_POINT) ? in_payload.a_y : in_payload.b_y;
            query_reg.hi_z <= (in_payload.opcode == OP_POINT) ? in_payload.a_z : in_payload.b_z;
        end
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    assign sts.scan_needed = ((in_payload.opcode == OP_POINT) || (in_payload.opcode == OP_BOX)) &&
                             (count_reg != '0);
    assign sts.scan_last   = (CW'(rd_idx_reg) == count_reg - CW'(1));
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_payload = out_reg;

endmodule

### rtl/aotc_checker.sv
`include "aabb_obstacle_table_check_unit_macros.svh"

module aotc_checker import aotc_pkg::*; #(
    parameter int MAX_BOXES = 64
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] in_opcode,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_clear,
    input logic       out_status
);

    localparam int CW = $clog2(MAX_BOXES + 1);

    logic [CW-1:0] add_cnt_reg;
    logic [1:0]    pend_op_reg;
    logic          pend_full_reg;
    logic          slot_free_reg;
    logic          in_xfer;
    logic          new_result;

    assign in_xfer    = in_valid && in_ready;
    // A result shown now is new if the output slot was free in the last cycle.
    assign new_result = out_valid && slot_free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_cnt_reg   <= '0;
            pend_op_reg   <= OP_BOX;
            pend_full_reg <= 1'b0;
            slot_free_reg <= 1'b1;
        end
        else
        begin
            slot_free_reg <= !out_valid || out_ready;
            if (in_xfer)
            begin
                pend_op_reg   <= in_opcode;
                pend_full_reg <= (add_cnt_reg == CW'(MAX_BOXES));
                if ((in_opcode == OP_ADD) && (add_cnt_reg != CW'(MAX_BOXES)))
                begin
                    add_cnt_reg <= add_cnt_reg + CW'(1);
                end
            end
        end
    end

    `AOTC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `AOTC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_clear) && $stable(out_status))
    `AOTC_ASSERT_IMPLIES(a_add_not_clear, clk, rst_n, new_result && (pend_op_reg == OP_ADD), !out_clear)
    `AOTC_ASSERT_IMPLIES(a_status_full, clk, rst_n, new_result, out_status == ((pend_op_reg == OP_ADD) && pend_full_reg))

endmodule

bind aabb_obstacle_table_check_unit aotc_checker #(
    .MAX_BOXES (MAX_BOXES)
) u_aotc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_opcode  (in_ch.payload.opcode),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_clear  (out_ch.payload.clear),
    .out_status (out_ch.payload.status)
);
